>>> rtl/core/fragment_reassembly_checker_assert.svh
// Assertion macros used by the checker file frc_checker.sv.
`ifndef FRAGMENT_REASSEMBLY_CHECKER_ASSERT_SVH
`define FRAGMENT_REASSEMBLY_CHECKER_ASSERT_SVH

// same-cycle implication
`define FRC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frc assertion failed");

// next-cycle implication
`define FRC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frc assertion failed");

`endif

>>> rtl/core/frc_pkg.sv
`timescale 1ns / 1ps

package frc_pkg;

    localparam int POOL_SLOTS   = 8;

    localparam int GEN_W        = 32;
    localparam int PAYLOAD_W    = 24;
    localparam int LEN_W        = 32;
    localparam int FRAG_W       = 16;
    localparam int SLOT_W       = 3;
    localparam int CNT_W        = 32;
    localparam int DROPS_W      = 2;

    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CURRENT_GENERATION = 2'd0,
        REG_MAX_PAYLOAD        = 2'd1,
        REG_MAX_FRAGMENT       = 2'd2
    } frc_reg_t;

    typedef enum logic {
        OP_FRAGMENT = 1'b0,
        OP_RESET    = 1'b1
    } frc_op_t;

    // packed MSB first, so the first field lands in the high bits
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [FRAG_W-1:0] frag_length;
        logic [LEN_W-1:0]  frag_offset;
        logic [LEN_W-1:0]  payload_length;
        logic              link_up;
        logic [GEN_W-1:0]  frag_generation;
    } frc_in_t;

    typedef struct packed {
        logic [CNT_W-1:0]     message_total;
        logic [CNT_W-1:0]     drop_total;
        logic [DROPS_W-1:0]   drops_added;
        logic [PAYLOAD_W-1:0] message_length;
        logic                 message_done;
        logic                 release_res;
        logic [SLOT_W-1:0]    slot_out;
        logic [FRAG_W-1:0]    write_length;
        logic [PAYLOAD_W-1:0] write_offset;
        logic                 write_enable;
        logic                 stale;
    } frc_out_t;

    localparam int IN_BITS     = $bits(frc_in_t);
    localparam int OUT_BITS    = $bits(frc_out_t);
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

endpackage

>>> rtl/core/fragment_reassembly_checker.sv
`timescale 1ns / 1ps

// Fragment reassembly checker.
// Slave stream s_*: one fragment descriptor per transfer. s_tuser is the
// operation (0 fragment, 1 clear reassembly state). Master stream m_*: one
// result per descriptor, in order. Configuration registers (generation, max
// payload, max fragment) are written through cfg_we/cfg_index/cfg_data and
// must only change while no descriptor is in flight.
// A descriptor accepted into the input register is decided there, and its result
// is registered in the result register, where m_tvalid goes high.
// Throughput: one descriptor per cycle while the result is not stalled; the
// reassembly state is updated as a descriptor moves from the input to the
// result register, so a descriptor may follow the previous one directly.
// Reset: clears the reassembly state, counters and both pipeline valid flags;
// configuration returns to generation 0, max payload 65536, max fragment 4096.
// Stall: while m_tready is low the result holds; one more descriptor is taken
// into the input register, after which s_tready drops until the result moves.
module fragment_reassembly_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // frag_generation, link_up, payload_length, frag_offset, frag_length, slot
    input  logic [frc_pkg::IN_TDATA_W-1:0] s_tdata,
    // operation
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // stale, write_enable, write_offset, write_length, slot_out, release_res,
    // message_done, message_length, drops_added, drop_total, message_total
    output logic [frc_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                          cfg_we,
    input  logic [frc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [frc_pkg::CFG_DATA_W-1:0] cfg_data
);

    import frc_pkg::*;

    logic                 in_valid_reg, in_valid_next;
    frc_op_t              in_op_reg, in_op_next;
    frc_in_t              in_reg, in_next;
    logic                 out_valid_reg, out_valid_next;
    frc_out_t             out_reg, out_next;

    logic [GEN_W-1:0]     cur_gen_reg, cur_gen_next;
    logic [PAYLOAD_W-1:0] max_payload_reg, max_payload_next;
    logic [FRAG_W-1:0]    max_frag_reg, max_frag_next;

    logic [PAYLOAD_W-1:0] received_reg, received_next;
    logic [LEN_W-1:0]     expected_reg, expected_next;
    logic                 assembling_reg, assembling_next;
    logic                 discarding_reg, discarding_next;
    logic [CNT_W-1:0]     drop_cnt_reg, drop_cnt_next;
    logic [CNT_W-1:0]     msg_cnt_reg, msg_cnt_next;

    logic                 advance;
    logic                 accept;
    frc_out_t             res;

    logic                 slot_ok;
    logic [LEN_W:0]       frag_end;
    logic [PAYLOAD_W-1:0] recv_e;
    logic [LEN_W-1:0]     exp_e;
    logic                 asm_e;
    logic                 disc_e;
    logic                 valid;
    logic                 final_frag;
    logic                 done;
    logic [DROPS_W-1:0]   drops;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, out_reg};

    // input register
    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_op_next    = in_op_reg;
        in_next       = in_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
            in_op_next    = frc_op_t'(s_tuser);
            in_next       = frc_in_t'(s_tdata[IN_BITS-1:0]);
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    // configuration
    always_comb
    begin
        cur_gen_next     = cur_gen_reg;
        max_payload_next = max_payload_reg;
        max_frag_next    = max_frag_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_CURRENT_GENERATION: cur_gen_next     = cfg_data[GEN_W-1:0];
                REG_MAX_PAYLOAD:        max_payload_next = cfg_data[PAYLOAD_W-1:0];
                REG_MAX_FRAGMENT:       max_frag_next    = cfg_data[FRAG_W-1:0];
                default:                ;
            endcase
        end
    end

    // reassembly decision
    always_comb
    begin
        slot_ok  = 32'(in_reg.slot) < POOL_SLOTS;
        frag_end = {1'b0, in_reg.frag_offset} + (LEN_W + 1)'(in_reg.frag_length);

        if (in_reg.frag_offset == '0)
        begin
            recv_e = '0;
            exp_e  = in_reg.payload_length;
            asm_e  = in_reg.payload_length <= LEN_W'(max_payload_reg);
            disc_e = !asm_e;
        end
        else
        begin
            recv_e = received_reg;
            exp_e  = expected_reg;
            asm_e  = assembling_reg;
            disc_e = discarding_reg;
        end

        valid = asm_e && !disc_e && (in_reg.payload_length == exp_e)
             && (in_reg.frag_offset == LEN_W'(recv_e))
             && (in_reg.frag_length <= max_frag_reg)
             && (frag_end <= (LEN_W + 1)'(max_payload_reg)) && slot_ok;
        final_frag = (in_reg.payload_length != '0)
                  && (frag_end >= {1'b0, in_reg.payload_length});

        received_next   = received_reg;
        expected_next   = expected_reg;
        assembling_next = assembling_reg;
        discarding_next = discarding_reg;
        drop_cnt_next   = drop_cnt_reg;
        msg_cnt_next    = msg_cnt_reg;
        done            = 1'b0;
        drops           = '0;
        res             = '0;

        if (in_op_reg == OP_RESET)
        begin
            received_next   = '0;
            expected_next   = '0;
            assembling_next = 1'b0;
            discarding_next = 1'b0;
        end
        else if (in_reg.frag_generation != cur_gen_reg || !in_reg.link_up)
        begin
            res.stale = 1'b1;
        end
        else
        begin
            received_next   = recv_e;
            expected_next   = exp_e;
            assembling_next = asm_e;
            discarding_next = disc_e;
            if (valid)
            begin
                res.write_enable = 1'b1;
                res.write_offset = in_reg.frag_offset[PAYLOAD_W-1:0];
                res.write_length = in_reg.frag_length;
                received_next    = frag_end[PAYLOAD_W-1:0];
            end
            else
            begin
                drops           = drops + DROPS_W'(1);
                discarding_next = 1'b1;
            end
            if (final_frag)
            begin
                if (valid && (LEN_W'(received_next) == exp_e))
                begin
                    done                = 1'b1;
                    res.message_length  = received_next;
                    msg_cnt_next        = msg_cnt_reg + CNT_W'(1);
                end
                else
                begin
                    drops = drops + DROPS_W'(1);
                end
                received_next   = '0;
                expected_next   = '0;
                assembling_next = 1'b0;
                discarding_next = 1'b0;
            end
            drop_cnt_next = drop_cnt_reg + CNT_W'(drops);
        end

        if (in_op_reg != OP_RESET)
        begin
            res.slot_out    = in_reg.slot;
            res.release_res = slot_ok;
        end
        res.message_done  = done;
        res.drops_added   = drops;
        res.drop_total    = drop_cnt_next;
        res.message_total = msg_cnt_next;

        if (!advance)
        begin
            received_next   = received_reg;
            expected_next   = expected_reg;
            assembling_next = assembling_reg;
            discarding_next = discarding_reg;
            drop_cnt_next   = drop_cnt_reg;
            msg_cnt_next    = msg_cnt_reg;
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            cur_gen_reg     <= '0;
            max_payload_reg <= PAYLOAD_W'(65536);
            max_frag_reg    <= FRAG_W'(4096);
            received_reg    <= '0;
            expected_reg    <= '0;
            assembling_reg  <= 1'b0;
            discarding_reg  <= 1'b0;
            drop_cnt_reg    <= '0;
            msg_cnt_reg     <= '0;
        end
        else
        begin
            in_valid_reg    <= in_valid_next;
            out_valid_reg   <= out_valid_next;
            cur_gen_reg     <= cur_gen_next;
            max_payload_reg <= max_payload_next;
            max_frag_reg    <= max_frag_next;
            received_reg    <= received_next;
            expected_reg    <= expected_next;
            assembling_reg  <= assembling_next;
            discarding_reg  <= discarding_next;
            drop_cnt_reg    <= drop_cnt_next;
            msg_cnt_reg     <= msg_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_op_reg <= in_op_next;
        in_reg    <= in_next;
        out_reg   <= out_next;
    end

endmodule

>>> rtl/core/frc_checker.sv
`timescale 1ns / 1ps

`include "fragment_reassembly_checker_assert.svh"

module frc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [frc_pkg::OUT_TDATA_W-1:0] m_tdata
);

    import frc_pkg::*;

    frc_out_t res;

    assign res = frc_out_t'(m_tdata[OUT_BITS-1:0]);

    `FRC_ASSERT_NXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `FRC_ASSERT_IMP(a_stale_quiet, m_tvalid && res.stale,
        !res.write_enable && !res.message_done && res.drops_added == '0)
    `FRC_ASSERT_IMP(a_done_needs_copy, m_tvalid && res.message_done,
        res.write_enable && res.release_res && res.message_length != '0)
    `FRC_ASSERT_IMP(a_drops_range, m_tvalid, res.drops_added != 2'd3)

endmodule

bind fragment_reassembly_checker frc_checker u_frc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
